// ===== hdl/bfpu_pkg.sv =====
// ============================================================================
// Bit field packer/unpacker package
// Shared types, request codes, status codes and field helper functions.
// ============================================================================
package bfpu_pkg;

  // Default store size in bytes and the byte window touched by one access.
  localparam int STORE_BYTES_DEF = 4096;
  localparam int WINDOW_BYTES    = 9;
  localparam int FIELD_MAX       = 64;

  typedef enum logic [2:0] {
    REQ_WRITE  = 3'd0,
    REQ_READ   = 3'd1,
    REQ_SEEK   = 3'd2,
    REQ_SKIP   = 3'd3,
    REQ_ALIGN  = 3'd4,
    REQ_REWIND = 3'd5
  } req_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_LEN  = 2'd1,
    STAT_PAST_END = 2'd2
  } stat_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_ACCESS,
    ST_DONE
  } state_t;

  // Mask of the low bits of a field; bits is 1 to 64.
  function automatic logic [63:0] field_mask(input logic [6:0] bits);
    logic [63:0] m;
    if (bits >= 7'(FIELD_MAX)) begin
      m = '1;
    end else begin
      m = (64'd1 << bits) - 64'd1;
    end
    return m;
  endfunction

  // Reverses the order of the low n bytes of v (n is 1 to 8).
  function automatic logic [63:0] swap_low(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] r;
    logic [2:0]  dst;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      dst = 3'(n - 4'd1 - 4'(i));
      if (4'(i) < n) begin
        r[8*dst +: 8] = v[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/bit_field_packer_unpacker_top.sv =====
// ============================================================================
// Bit field packer/unpacker
// Byte store with a bit cursor; packs fields into and unpacks fields from
// the store one request at a time through a shared byte-wide access loop.
// ============================================================================
//
//  Channel   Handshake                  Payload
//  --------  -------------------------  -----------------------------------
//  request   start / busy               req_type, field_value, bit_count,
//                                       seek_byte, seek_bit
//  result    done (one-cycle strobe)    read_value, status, bytes_used
//  config    cfg_valid / cfg_ready      cfg_data (big-endian select)
//
// A read or write transaction walks the nine-byte window at the cursor one byte
// a cycle through the single read and write ports of the store, and a new
// transaction may start in the cycle in which done is high. Seek, skip, align,
// rewind, spare codes and rejected fields go from decode straight to done
// without the access loop. After reset busy stays high while the store is
// swept to zero; configuration writes are taken at any time. The receiver
// cannot stall: a result lasts one done cycle.
// ============================================================================
module bit_field_packer_unpacker_top
  import bfpu_pkg::*;
#(
  parameter int STORE_BYTES = STORE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Request channel
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [63:0] field_value,
  input  logic [14:0] bit_count,
  input  logic [11:0] seek_byte,
  input  logic [2:0]  seek_bit,
  // Result channel
  output logic        done,
  output logic [63:0] read_value,
  output logic [1:0]  status,
  output logic [12:0] bytes_used,
  // Configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  // Address width of the store, cursor byte width (it may equal the store
  // size), and a bit position width wide enough for cursor plus skip length.
  localparam int AW  = $clog2(STORE_BYTES);
  localparam int CW  = $clog2(STORE_BYTES + 1);
  localparam int SW  = ((CW + 3) > 15 ? (CW + 3) : 15) + 1;
  localparam int UW  = ((CW + 1) > 13 ? (CW + 1) : 13);
  localparam logic [SW-1:0] END_POS = SW'(STORE_BYTES) << 3;
  localparam int WIN_BITS = 8 * WINDOW_BYTES;

  // Control registers.
  state_t         state, state_next;
  logic [CW-1:0]  cursor_byte;
  logic [2:0]     cursor_bit;
  logic           big_endian;
  logic [AW-1:0]  clr_addr;
  logic [3:0]     step;

  // Latched request.
  req_t           req_r;
  logic [63:0]    val_r;
  logic [14:0]    bits_r;
  logic [11:0]    seek_byte_r;
  logic [2:0]     seek_bit_r;

  // Access loop registers.
  stat_t          stat_r;
  logic [CW-1:0]  base_r;
  logic [2:0]     shamt_r;
  logic [WIN_BITS-1:0] win;
  logic           rd_ok_d;
  logic [AW-1:0]  rd_idx_d;

  // Byte store.
  logic [7:0]     mem [STORE_BYTES];
  logic [7:0]     mem_q;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [7:0]     mem_wdata;

  // Decode-stage signals.
  logic           is_access;
  logic           len_bad;
  logic           past_end;
  logic [6:0]     bits7;
  logic [3:0]     nbytes;
  logic           do_swap;
  logic [SW-1:0]  here;
  logic [SW-1:0]  pos_target;
  logic [SW-1:0]  pos_clamped;
  logic [63:0]    wr_val;
  logic [63:0]    rd_val;
  logic [CW:0]    rd_addr;
  logic           rd_in_range;
  logic [7:0]     byte_in;
  logic [UW-1:0]  used_full;

  assign cfg_ready = 1'b1;

  // --------------------------------------------------------------------------
  // Next-state logic.
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == AW'(STORE_BYTES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (is_access && !len_bad && !past_end) begin
          state_next = ST_ACCESS;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_ACCESS: begin
        if (step == 4'(WINDOW_BYTES)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // State outputs: handshake and store write port.
  // --------------------------------------------------------------------------
  always_comb begin
    busy      = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wdata = 8'h00;
    unique case (state)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        busy = 1'b0;
      end
      ST_ACCESS: begin
        // Read-modify-write of the byte fetched in the previous cycle.
        mem_waddr = rd_idx_d;
        mem_wdata = mem_q | win[7:0];
        mem_we    = (req_r == REQ_WRITE) && (step != 4'd0) && rd_ok_d;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Request decode, cursor arithmetic and field shaping.
  // --------------------------------------------------------------------------
  always_comb begin
    is_access = (req_r == REQ_WRITE) || (req_r == REQ_READ);
    len_bad   = (bits_r == 15'd0) || (bits_r > 15'(FIELD_MAX));
    here      = SW'({cursor_byte, cursor_bit});
    past_end  = (here + SW'(bits_r)) > END_POS;
    bits7     = bits_r[6:0];
    nbytes    = 4'((8'(bits7) + 8'd7) >> 3);
    do_swap   = big_endian && (bits7 > 7'd8);

    pos_target = here;
    case (req_r) inside
      REQ_WRITE: begin
        if (!len_bad && !past_end) begin
          pos_target = here + SW'(bits_r);
        end
      end
      REQ_SEEK:   pos_target = SW'({seek_byte_r, seek_bit_r});
      REQ_SKIP:   pos_target = here + SW'(bits_r);
      REQ_ALIGN: begin
        if (cursor_bit != 3'd0) begin
          pos_target = SW'({(CW + 1)'(cursor_byte) + (CW + 1)'(1), 3'b000});
        end
      end
      REQ_REWIND: pos_target = '0;
      default:    pos_target = here;
    endcase
    pos_clamped = (pos_target > END_POS) ? END_POS : pos_target;

    wr_val = val_r & field_mask(bits7);
    if (do_swap) begin
      wr_val = swap_low(wr_val, nbytes);
    end

    rd_val = 64'(win >> shamt_r) & field_mask(bits7);
    if (do_swap) begin
      rd_val = swap_low(rd_val, nbytes);
    end

    rd_addr     = (CW + 1)'(base_r) + (CW + 1)'(step);
    rd_in_range = rd_addr < (CW + 1)'(STORE_BYTES);
    byte_in     = rd_ok_d ? mem_q : 8'h00;
    used_full   = UW'(cursor_byte) + UW'(cursor_bit != 3'd0);
  end

  // --------------------------------------------------------------------------
  // Byte store: one write port, one registered read port.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_q <= mem[rd_addr[AW-1:0]];
  end

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      cursor_byte <= '0;
      cursor_bit  <= '0;
      big_endian  <= 1'b0;
      clr_addr    <= '0;
      step        <= '0;
      done        <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == ST_DONE);
      if (cfg_valid && cfg_ready) begin
        big_endian <= cfg_data;
      end
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (state == ST_DECODE) begin
        // The access loop works from base_r, so the cursor can move now.
        cursor_byte <= pos_clamped[CW+2:3];
        cursor_bit  <= pos_clamped[2:0];
        step        <= '0;
      end
      if (state == ST_ACCESS) begin
        step <= step + 4'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      req_r       <= req_t'(req_type);
      val_r       <= field_value;
      bits_r      <= bit_count;
      seek_byte_r <= seek_byte;
      seek_bit_r  <= seek_bit;
    end

    if (state == ST_DECODE) begin
      base_r  <= cursor_byte;
      shamt_r <= cursor_bit;
      win     <= WIN_BITS'(wr_val) << cursor_bit;
      if (is_access && len_bad) begin
        stat_r <= STAT_BAD_LEN;
      end else if (is_access && past_end) begin
        stat_r <= STAT_PAST_END;
      end else begin
        stat_r <= STAT_OK;
      end
    end

    if (state == ST_ACCESS) begin
      if (step != 4'(WINDOW_BYTES)) begin
        rd_ok_d  <= rd_in_range;
        rd_idx_d <= rd_addr[AW-1:0];
      end
      if (step != 4'd0) begin
        // Writes drain the window low byte first; reads fill it from the top.
        if (req_r == REQ_READ) begin
          win <= {byte_in, win[WIN_BITS-1:8]};
        end else begin
          win <= win >> 8;
        end
      end
    end

    if (state == ST_DONE) begin
      status     <= stat_r;
      bytes_used <= used_full[12:0];
      if (req_r == REQ_READ && stat_r == STAT_OK) begin
        read_value <= rd_val;
      end else begin
        read_value <= '0;
      end
    end
  end

endmodule

// ===== verif/bit_field_packer_unpacker_top_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// Bit field packer/unpacker testbench
// Drives read, write, seek, skip, align and rewind transactions into the
// block, with both byte orders. It predicts every result from a shadow copy
// of the byte store and the cursor, and compares each result field by field.
// ============================================================================
module bit_field_packer_unpacker_top_tb;
  import bfpu_pkg::*;

  localparam int STORE_SIZE    = STORE_BYTES_DEF;
  localparam int STORE_BITS    = STORE_SIZE * 8;
  localparam int STALL_LIMIT   = 20000;
  localparam int REPORT_LIMIT  = 100;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_COUNT   = 6;
  localparam int PHASE_ITEMS   = 285;

  // Request codes that the block decodes as no-ops.
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  // One request transaction as the driver presents it. A set drain flag makes
  // the driver hold the request back until every earlier result has arrived.
  typedef struct {
    logic [2:0]  op;
    logic [63:0] value;
    logic [14:0] len;
    logic [11:0] to_byte;
    logic [2:0]  to_bit;
    bit          drain;
  } request_t;

  // The result fields that one request is predicted to produce.
  typedef struct {
    logic [63:0] field;
    stat_t       code;
    logic [12:0] used;
  } outcome_t;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        start       = 1'b0;
  logic [2:0]  req_type    = '0;
  logic [63:0] field_value = '0;
  logic [14:0] bit_count   = '0;
  logic [11:0] seek_byte   = '0;
  logic [2:0]  seek_bit    = '0;
  logic        cfg_valid   = 1'b0;
  logic        cfg_data    = 1'b0;
  logic        busy;
  logic        done;
  logic [63:0] read_value;
  logic [1:0]  status;
  logic [12:0] bytes_used;
  logic        cfg_ready;

  // Requests waiting to be driven, and results predicted for accepted
  // requests that have not come out yet (oldest first).
  request_t request_queue[$];
  outcome_t pending_results[$];
  request_t in_flight;

  // Shadow copy of the block state: the byte store, the bit cursor and the
  // byte order register.
  logic [7:0]  shadow_store [STORE_SIZE];
  int unsigned cur_byte;
  int unsigned cur_bit;
  bit          big_endian_mode;

  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;
  int unsigned gap_left    = 0;
  int unsigned burst_left  = 0;

  bit_field_packer_unpacker_top #(
    .STORE_BYTES(STORE_SIZE)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .field_value(field_value),
    .bit_count  (bit_count),
    .seek_byte  (seek_byte),
    .seek_bit   (seek_bit),
    .done       (done),
    .read_value (read_value),
    .status     (status),
    .bytes_used (bytes_used),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // 12 ns clock period.
  initial begin
    forever #6 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // All ones in the low n bits, for n from 1 to 64.
  function automatic logic [63:0] low_ones(input int unsigned n);
    return ~(64'hFFFF_FFFF_FFFF_FFFF << n);
  endfunction

  // Reverses the order of the low n bytes of a word and clears the rest.
  function automatic logic [63:0] reverse_bytes(input logic [63:0] v, input int unsigned n);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < n; i++) begin
      r[8*(n-1-i) +: 8] = v[8*i +: 8];
    end
    return r;
  endfunction

  // Moves the cursor to an absolute bit position. Anything past the end of
  // the store lands on the first bit after the last byte.
  function automatic void place_cursor(input int unsigned bitpos);
    int unsigned p;
    p = (bitpos > STORE_BITS) ? STORE_BITS : bitpos;
    cur_byte = p >> 3;
    cur_bit  = p & 7;
  endfunction

  // Applies one accepted request to the shadow state and returns the result
  // that the block must give for it.
  function automatic outcome_t apply_request(input request_t rq);
    outcome_t     res;
    int unsigned  here;
    int unsigned  len;
    logic [127:0] win;
    logic [63:0]  v;
    res.field = '0;
    res.code  = STAT_OK;
    here = cur_byte * 8 + cur_bit;
    len  = rq.len;
    case (rq.op)
      REQ_WRITE, REQ_READ: begin
        if (len == 0 || len > FIELD_MAX) begin
          res.code = STAT_BAD_LEN;
        end else if (here + len > STORE_BITS) begin
          res.code = STAT_PAST_END;
        end else if (rq.op == REQ_WRITE) begin
          v = rq.value & low_ones(len);
          if (len > 8 && big_endian_mode) begin
            v = reverse_bytes(v, (len + 7) / 8);
          end
          // New bits are ORed in; window bytes past the store are dropped.
          win = {64'd0, v} << cur_bit;
          for (int k = 0; k < WINDOW_BYTES; k++) begin
            if (cur_byte + k < STORE_SIZE) begin
              shadow_store[cur_byte + k] |= win[8*k +: 8];
            end
          end
          place_cursor(here + len);
        end else begin
          // Bytes past the end of the store read as zero.
          win = '0;
          for (int k = 0; k < WINDOW_BYTES; k++) begin
            if (cur_byte + k < STORE_SIZE) begin
              win[8*k +: 8] = shadow_store[cur_byte + k];
            end
          end
          v = 64'(win >> cur_bit) & low_ones(len);
          if (len > 8 && big_endian_mode) begin
            v = reverse_bytes(v, (len + 7) / 8);
          end
          res.field = v;
        end
      end
      REQ_SEEK: place_cursor(rq.to_byte * 8 + rq.to_bit);
      REQ_SKIP: place_cursor(here + len);
      REQ_ALIGN: begin
        if (cur_bit != 0) begin
          place_cursor((cur_byte + 1) * 8);
        end
      end
      REQ_REWIND: begin
        cur_byte = 0;
        cur_bit  = 0;
      end
      default: ;
    endcase
    res.used = 13'(cur_byte + (cur_bit != 0));
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------

  // Idle cycles after a request. Most gaps are short, a few are long, and now
  // and then a burst of requests goes out back to back.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A request is accepted at a rising edge with start high and busy low. The
  // prediction is made at that edge, so it sees exactly the requests that the
  // block has taken before. Start is written once per edge, so a request that
  // follows straight on keeps start high without a glitch.
  always @(posedge clk) begin : request_driver
    request_t nxt;
    bit       launch;
    launch = 1'b0;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        pending_results.push_back(apply_request(in_flight));
      end
      if (!start || !busy) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (request_queue.size() != 0 &&
                     !(request_queue[0].drain && pending_results.size() != 0)) begin
          nxt         = request_queue.pop_front();
          in_flight   = nxt;
          launch      = 1'b1;
          req_type    <= nxt.op;
          field_value <= nxt.value;
          bit_count   <= nxt.len;
          seek_byte   <= nxt.to_byte;
          seek_bit    <= nxt.to_bit;
          gap_left    = pick_gap();
        end
        start <= launch;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor
  // --------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (got_v !== exp_v) begin
      error_count++;
      // Reports stop after a while so a broken block cannot flood the log.
      if (error_count <= REPORT_LIMIT) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      end
    end
  endtask

  // The done strobe lasts one cycle and cannot be held off, so a result is
  // taken at every edge where done is high. The same block counts cycles in
  // which no request, result or configuration write is seen, for the watchdog.
  always @(posedge clk) begin : result_monitor
    outcome_t want;
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (done) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("%0t: result with no request pending: expected none, actual %h/%0d/%0d",
                     $time, read_value, status, bytes_used);
          end
        end else begin
          want = pending_results.pop_front();
          check_field("read_value", want.field, read_value);
          check_field("status", 64'(want.code), 64'(status));
          check_field("bytes_used", 64'(want.used), 64'(bytes_used));
        end
      end
    end
  end

  // The limit covers the clearing sweep after reset, a long sender gap and
  // the slowest transaction, many times over.
  initial begin : stall_watchdog
    wait (idle_cycles >= STALL_LIMIT);
    $display("FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Field lengths: short fields, multi-byte fields and the full 64 bits.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return $urandom_range(1, 8);
    if (r < 9) return $urandom_range(9, 63);
    return 64;
  endfunction

  // About one request in a hundred waits for the block to drain first.
  task automatic queue_request(input logic [2:0] op, input logic [63:0] value,
                               input int unsigned len, input int unsigned to_byte,
                               input int unsigned to_bit);
    request_t rq;
    rq.op      = op;
    rq.value   = value;
    rq.len     = 15'(len);
    rq.to_byte = 12'(to_byte);
    rq.to_bit  = 3'(to_bit);
    rq.drain   = ($urandom_range(0, 99) == 0);
    request_queue.push_back(rq);
  endtask

  // Writes the byte order register. Only called with nothing in flight.
  task automatic set_byte_order(input bit be);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= be;
    do @(posedge clk); while (!cfg_ready);
    big_endian_mode = be;
    cfg_valid <= 1'b0;
  endtask

  // Returns once every queued request has been taken and every predicted
  // result has come out. The watchdog bounds the wait.
  task automatic wait_until_drained();
    while (request_queue.size() != 0 || start || pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Random requests. Most of them form round trips: seek somewhere, write a
  // few fields, seek back and read each field, skipping over it afterwards
  // because a read leaves the cursor in place. The rest are single requests
  // at the current cursor and raw noise over the whole range of every field.
  task automatic queue_random_phase(input int unsigned n);
    int unsigned made;
    int unsigned pick;
    int unsigned fields;
    int unsigned pos_byte;
    int unsigned pos_bit;
    int unsigned lens [8];
    made = 0;
    while (made < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        fields   = $urandom_range(1, 6);
        pos_byte = ($urandom_range(0, 9) == 0) ? $urandom_range(STORE_SIZE - 48, STORE_SIZE - 1)
                                               : $urandom_range(0, STORE_SIZE - 1);
        pos_bit  = $urandom_range(0, 7);
        queue_request(REQ_SEEK, rand_word(), $urandom_range(0, 32767), pos_byte, pos_bit);
        for (int i = 0; i < fields; i++) begin
          lens[i] = pick_len();
          queue_request(REQ_WRITE, rand_word(), lens[i], $urandom_range(0, 4095),
                        $urandom_range(0, 7));
        end
        queue_request(REQ_SEEK, rand_word(), $urandom_range(0, 32767), pos_byte, pos_bit);
        for (int i = 0; i < fields; i++) begin
          queue_request(REQ_READ, rand_word(), lens[i], $urandom_range(0, 4095),
                        $urandom_range(0, 7));
          queue_request(REQ_SKIP, rand_word(), lens[i], $urandom_range(0, 4095),
                        $urandom_range(0, 7));
        end
        made += 2 + 3 * fields;
      end else if (pick < 80) begin
        case ($urandom_range(0, 5))
          0: queue_request(REQ_WRITE, rand_word(), pick_len(), 0, 0);
          1: queue_request(REQ_READ, rand_word(), pick_len(), 0, 0);
          2: queue_request(REQ_SEEK, rand_word(), 0, $urandom_range(0, 4095),
                           $urandom_range(0, 7));
          3: queue_request(REQ_SKIP, rand_word(), ($urandom_range(0, 9) == 0) ?
                           $urandom_range(0, 32767) : $urandom_range(0, 200), 0, 0);
          4: queue_request(REQ_ALIGN, rand_word(), 0, 0, 0);
          default: queue_request(REQ_REWIND, rand_word(), 0, 0, 0);
        endcase
        made++;
      end else begin
        queue_request(3'($urandom_range(0, 7)), rand_word(),
                      ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32767)
                                                  : $urandom_range(0, 70),
                      $urandom_range(0, 4095), $urandom_range(0, 7));
        made++;
      end
    end
  endtask

  initial begin : stimulus
    foreach (shadow_store[i]) shadow_store[i] = '0;
    cur_byte        = 0;
    cur_bit         = 0;
    big_endian_mode = 1'b0;

    // Reset is held from the start, then the block clears its store, which
    // keeps busy high for a while; the first request simply waits for it.
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed requests in little-endian order.
    set_byte_order(1'b0);
    queue_request(REQ_WRITE, '1, 64, 0, 0);           // full-width field of ones
    queue_request(REQ_REWIND, '0, 0, 0, 0);
    queue_request(REQ_READ, '0, 64, 0, 0);
    queue_request(REQ_SEEK, '0, 0, 16, 3);
    queue_request(REQ_WRITE, '1, 1, 0, 0);            // one bit, rest masked off
    queue_request(REQ_SEEK, '0, 0, 16, 3);
    queue_request(REQ_READ, '0, 1, 0, 0);
    queue_request(REQ_WRITE, rand_word(), 0, 0, 0);   // zero length is rejected
    queue_request(REQ_READ, '0, 65, 0, 0);            // so is a field over 64 bits
    queue_request(REQ_WRITE, rand_word(), 32767, 0, 0);
    queue_request(REQ_SKIP, '0, 32767, 0, 0);         // cursor saturates at the end
    queue_request(REQ_READ, '0, 1, 0, 0);             // nothing left to read
    queue_request(REQ_SEEK, '0, 0, 4095, 7);          // largest seek position
    queue_request(REQ_ALIGN, '0, 0, 0, 0);            // align onto the end
    // A field that ends on the last bit, so its window hangs past the store.
    queue_request(REQ_SEEK, '0, 0, 4095, 5);
    queue_request(REQ_WRITE, 64'h5, 3, 0, 0);
    queue_request(REQ_SEEK, '0, 0, 4095, 5);
    queue_request(REQ_READ, '0, 3, 0, 0);
    queue_request(REQ_SEEK, '0, 0, 4094, 2);
    queue_request(REQ_WRITE, '1, 16, 0, 0);           // two bits too long
    queue_request(REQ_SPARE_LO, rand_word(), 9, 7, 1);
    queue_request(REQ_SPARE_HI, rand_word(), 9, 7, 1);
    wait_until_drained();

    // Directed requests in big-endian order: a two-byte field is swapped on
    // the way in and back on the way out, while an 8-bit read sees raw bytes.
    set_byte_order(1'b1);
    queue_request(REQ_SEEK, '0, 0, 200, 3);
    queue_request(REQ_WRITE, 64'h1234, 16, 0, 0);
    queue_request(REQ_READ, '0, 16, 0, 0);
    queue_request(REQ_SEEK, '0, 0, 200, 3);
    queue_request(REQ_READ, '0, 16, 0, 0);
    queue_request(REQ_READ, '0, 8, 0, 0);
    wait_until_drained();

    // Random phases with the byte order alternating between them.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_byte_order(bit'(p % 2));
      queue_random_phase(PHASE_ITEMS);
      wait_until_drained();
    end

    // Any stray result in this window is caught by the monitor.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
